// ===== sv/bads_pkg.sv =====
`default_nettype none

package bads_pkg;

    // defaults for the top-level parameters
    localparam int MAX_OUT_WIDTH_DEF = 256;
    localparam int SAMPLE_BITS_DEF   = 16;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int DIM_W      = 16;
    localparam int SCALE_W    = 9;
    localparam int OFFSET_W   = 8;
    localparam int PARTIAL_W  = 24;
    localparam int ACC_W      = 32;
    localparam int AREA_W     = 17;
    localparam int AVG_W      = 16;
    localparam int NUM_LANES  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_SCALE  = 256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SCALE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE    = 8'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_DIV
    } t_state;

    // where the current pixel sits, from the position tracker
    typedef struct packed {
        logic keep;
        logic block_end;
        logic band_end;
        logic first_col;
        logic first_row;
        logic last;
    } t_pos_info;

    // per-lane controls from the sequencer
    typedef struct packed {
        logic load;
        logic first_col;
        logic rd;
        logic acc;
        logic first_row;
        logic go;
        logic clr;
    } t_lane_ctrl;

    // scale 0 acts as 1, anything above 256 as 256
    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
        logic [SCALE_W-1:0] res;
        if (raw == '0) begin
            res = SCALE_W'(1);
        end else if (raw > SCALE_W'(MAX_SCALE)) begin
            res = SCALE_W'(MAX_SCALE);
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bads_ram.sv =====
`default_nettype none

module bads_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/bads_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module bads_div #(
    parameter int DW = 32,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder,
    output logic          o_busy,
    output logic          o_done
);

    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;
    logic [VW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DW-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? diff[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_busy      = r_busy;
    assign o_done      = r_done;

endmodule

`default_nettype wire

// ===== sv/bads_pos.sv =====
`default_nettype none

// raster position, block/band counters and the block-column/row indexes
module bads_pos #(
    parameter int MAX_OUT_WIDTH = bads_pkg::MAX_OUT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_recalc,
    input  logic [bads_pkg::DIM_W-1:0]        i_width,
    input  logic [bads_pkg::DIM_W-1:0]        i_height,
    input  logic [bads_pkg::SCALE_W-1:0]      i_scale,
    output bads_pkg::t_pos_info               o_info,
    output logic [$clog2(MAX_OUT_WIDTH)-1:0]  o_bc,
    output logic                              o_busy
);

    import bads_pkg::*;

    localparam int AW = $clog2(MAX_OUT_WIDTH);
    localparam logic [DIM_W-1:0] MaxOut = DIM_W'(MAX_OUT_WIDTH);

    typedef enum logic [1:0] {
        RC_WIDTH,
        RC_HEIGHT,
        RC_COL,
        RC_ROW
    } t_rc_step;

    logic [DIM_W-1:0]    r_col, r_row, r_cq, r_rq, r_ws, r_hs;
    logic [OFFSET_W-1:0] r_off, r_rib, r_cr, r_rr;
    logic                r_busy, r_go;
    t_rc_step            r_step;

    logic [DIM_W-1:0]    wout;
    logic                col_wrap, row_wrap, block_end, band_end, cr_wrap, rr_wrap;
    logic [DIM_W-1:0]    div_dividend;
    logic [DIM_W-1:0]    div_quo;
    logic [SCALE_W-1:0]  div_rem;
    logic                div_busy, div_done, div_take;

    // recalculation: width, height, column and row each divided by the scale
    always_comb begin
        case (r_step)
            RC_WIDTH:  div_dividend = i_width;
            RC_HEIGHT: div_dividend = i_height;
            RC_COL:    div_dividend = r_col;
            RC_ROW:    div_dividend = r_row;
            default:   div_dividend = i_width;
        endcase
    end

    bads_div #(
        .DW (DIM_W),
        .VW (SCALE_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_go),
        .i_dividend  (div_dividend),
        .i_divisor   (i_scale),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_busy      (div_busy),
        .o_done      (div_done)
    );

    // a done from a run cut short by a restart is dropped
    assign div_take = div_done && r_busy && !r_go;

    always_comb begin
        wout      = (r_ws < MaxOut) ? r_ws : MaxOut;
        col_wrap  = ({1'b0, r_col} + 17'd1) >= {1'b0, i_width};
        row_wrap  = ({1'b0, r_row} + 17'd1) >= {1'b0, i_height};
        block_end = ({1'b0, r_off} + 9'd1) >= i_scale;
        band_end  = ({1'b0, r_rib} + 9'd1) >= i_scale;
        cr_wrap   = ({1'b0, r_cr} + 9'd1) >= i_scale;
        rr_wrap   = ({1'b0, r_rr} + 9'd1) >= i_scale;

        o_info.keep      = (r_cq < wout) && (r_rq < r_hs);
        o_info.block_end = block_end;
        o_info.band_end  = band_end;
        o_info.first_col = (r_off == '0);
        o_info.first_row = (r_rib == '0);
        o_info.last      = (({1'b0, r_rq} + 17'd1) == {1'b0, r_hs})
                        && (({1'b0, r_cq} + 17'd1) == {1'b0, wout});
    end

    assign o_bc   = r_cq[AW-1:0];
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_off  <= '0;
            r_rib  <= '0;
            r_cq   <= '0;
            r_cr   <= '0;
            r_rq   <= '0;
            r_rr   <= '0;
            r_ws   <= DIM_W'(1);
            r_hs   <= DIM_W'(1);
            r_busy <= 1'b0;
            r_go   <= 1'b0;
            r_step <= RC_WIDTH;
        end else begin
            r_go <= 1'b0;
            if (i_recalc) begin
                r_busy <= 1'b1;
                r_step <= RC_WIDTH;
                r_go   <= 1'b1;
            end else if (div_take) begin
                case (r_step)
                    RC_WIDTH: begin
                        r_ws   <= div_quo;
                        r_step <= RC_HEIGHT;
                        r_go   <= 1'b1;
                    end
                    RC_HEIGHT: begin
                        r_hs   <= div_quo;
                        r_step <= RC_COL;
                        r_go   <= 1'b1;
                    end
                    RC_COL: begin
                        r_cq   <= div_quo;
                        r_cr   <= div_rem[OFFSET_W-1:0];
                        r_step <= RC_ROW;
                        r_go   <= 1'b1;
                    end
                    RC_ROW: begin
                        r_rq   <= div_quo;
                        r_rr   <= div_rem[OFFSET_W-1:0];
                        r_busy <= 1'b0;
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end

            if (i_advance) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_cq  <= '0;
                    r_cr  <= '0;
                    r_off <= '0;
                    if (row_wrap) begin
                        r_row <= '0;
                        r_rq  <= '0;
                        r_rr  <= '0;
                        r_rib <= '0;
                    end else begin
                        r_row <= r_row + DIM_W'(1);
                        r_rib <= band_end ? '0 : r_rib + OFFSET_W'(1);
                        if (rr_wrap) begin
                            r_rr <= '0;
                            r_rq <= r_rq + DIM_W'(1);
                        end else begin
                            r_rr <= r_rr + OFFSET_W'(1);
                        end
                    end
                end else begin
                    r_col <= r_col + DIM_W'(1);
                    r_off <= block_end ? '0 : r_off + OFFSET_W'(1);
                    if (cr_wrap) begin
                        r_cr <= '0;
                        r_cq <= r_cq + DIM_W'(1);
                    end else begin
                        r_cr <= r_cr + OFFSET_W'(1);
                    end
                end
            end
        end
    end

`ifndef SYNTH
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (({1'b0, r_cr} < i_scale) && ({1'b0, r_rr} < i_scale)))
        else $error("block remainder not below scale");
    a_no_pixel_in_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |-> (!r_busy && !div_busy))
        else $error("pixel taken during recalculation");
    a_go_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_go |-> r_busy)
        else $error("divider started outside recalculation");
`endif

endmodule

`default_nettype wire

// ===== sv/bads_lane.sv =====
`default_nettype none

// one colour channel: row partial, column accumulator memory, divider
module bads_lane #(
    parameter int MAX_OUT_WIDTH = bads_pkg::MAX_OUT_WIDTH_DEF,
    parameter int SAMPLE_BITS   = bads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  bads_pkg::t_lane_ctrl             i_ctrl,
    input  logic [$clog2(MAX_OUT_WIDTH)-1:0] i_addr,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic [bads_pkg::AREA_W-1:0]      i_area,
    output logic [bads_pkg::AVG_W-1:0]       o_avg,
    output logic                             o_busy
);

    import bads_pkg::*;

    localparam int AW = $clog2(MAX_OUT_WIDTH);

    logic [PARTIAL_W-1:0] r_partial;
    logic [ACC_W-1:0]     rd_data, sum, wr_data, quo;
    logic                 wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
        end else if (i_ctrl.load && i_en) begin
            r_partial <= i_ctrl.first_col ? PARTIAL_W'(i_sample)
                                          : r_partial + PARTIAL_W'(i_sample);
        end
    end

    // first row of a band overwrites the column sum
    always_comb begin
        sum     = i_ctrl.first_row ? ACC_W'(r_partial) : rd_data + ACC_W'(r_partial);
        wr_data = i_ctrl.clr ? '0 : sum;
        wr_en   = i_ctrl.clr || (i_ctrl.acc && i_en);
    end

    bads_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_ctrl.rd),
        .i_rd_addr (i_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    bads_div #(
        .DW (ACC_W),
        .VW (AREA_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_ctrl.go),
        .i_dividend  (sum),
        .i_divisor   (i_area),
        .o_quotient  (quo),
        .o_remainder (),
        .o_busy      (o_busy),
        .o_done      ()
    );

    assign o_avg = i_en ? quo[AVG_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== sv/box_average_downscaler_core.sv =====
`default_nettype none

// Box-average downscaler. Pixels come in raster order, one per input beat, and
// every block_scale x block_scale square is averaged into one output pixel
// (block sum divided by scale squared, truncated); trailing columns and rows
// that do not fill a whole block are dropped, as are output columns at or
// beyond MAX_OUT_WIDTH. Three channel lanes run side by side, each with its
// own row partial, column-sum memory and divider; the output register merges
// them. A pixel that closes no block row in a kept column is simply taken, one
// that closes a block row also does a read-modify-write of the column memory,
// and one that closes a whole block waits for the 32-step restoring divider
// in each lane. After each configuration write the block divides width,
// height and the current position by the scale in turn, and after reset it
// sweeps every address of the column memories to clear them; no pixel is taken
// meanwhile, config beats always are. Configuration: index 0 frame width,
// 1 frame height, 2 block scale, 3 mono flag (only lane 0 carries data, red
// and green read zero).
module box_average_downscaler_core #(
    parameter int MAX_OUT_WIDTH = bads_pkg::MAX_OUT_WIDTH_DEF,
    parameter int SAMPLE_BITS   = bads_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input pixel stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [47:0]                       i_s_axis_tdata,  // sample_red, sample_green, sample_blue
    // output pixel stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [47:0]                       o_m_axis_tdata,  // avg_red, avg_green, avg_blue
    output logic                              o_m_axis_tlast,  // last_pixel
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bads_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bads_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import bads_pkg::*;

    localparam int AW = $clog2(MAX_OUT_WIDTH);

    // configuration
    logic [DIM_W-1:0]     r_frame_width, r_frame_height;
    logic [SCALE_W-1:0]   r_block_scale;
    logic                 r_mono_mode;
    logic [SCALE_W-1:0]   scale_eff;
    logic [2*SCALE_W-1:0] area_full;
    logic [AREA_W-1:0]    r_block_area;
    logic                 cfg_wr;

    // sequencing
    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_cnt;
    logic [AW-1:0]        r_bc, pos_bc, lane_addr;
    logic                 r_band_end, r_first_row, r_last;
    t_pos_info            pos_info;
    logic                 pos_busy;
    t_lane_ctrl           lane_ctrl;
    logic                 s_ready, accept, take_block, load_out, lanes_idle;

    // lanes and output register
    logic [NUM_LANES-1:0] lane_en, lane_busy;
    logic [AVG_W-1:0]     lane_avg [NUM_LANES];
    logic                 r_out_valid, r_out_last;
    logic [AVG_W-1:0]     r_out_avg [NUM_LANES];

    // ---- configuration registers --------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(1);
            r_frame_height <= DIM_W'(1);
            r_block_scale  <= SCALE_W'(1);
            r_mono_mode    <= 1'b1;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                CFG_BLOCK_SCALE:  r_block_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_MONO_MODE:    r_mono_mode    <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // divisor for the block average; settles well within the recalculation
    assign scale_eff = eff_scale(r_block_scale);
    assign area_full = scale_eff * scale_eff;

    always_ff @(posedge i_clk) begin
        r_block_area <= area_full[AREA_W-1:0];
    end

    // ---- position tracker ---------------------------------------------------
    bads_pos #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_recalc  (cfg_wr),
        .i_width   (r_frame_width),
        .i_height  (r_frame_height),
        .i_scale   (scale_eff),
        .o_info    (pos_info),
        .o_bc      (pos_bc),
        .o_busy    (pos_busy)
    );

    // ---- sequencer ----------------------------------------------------------
    assign accept     = i_s_axis_tvalid && s_ready;
    assign take_block = accept && pos_info.block_end && pos_info.keep;
    assign lanes_idle = (lane_busy == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == AW'(MAX_OUT_WIDTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take_block) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = r_band_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (lanes_idle && (!r_out_valid || i_m_axis_tready)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        load_out  = 1'b0;
        lane_addr = pos_bc;
        lane_ctrl = '0;
        lane_ctrl.first_col = pos_info.first_col;
        lane_ctrl.first_row = r_first_row;
        case (r_state)
            S_CLEAR: begin
                lane_ctrl.clr = 1'b1;
                lane_addr     = r_clr_cnt;
            end
            S_IDLE: begin
                s_ready        = !pos_busy;
                lane_ctrl.load = accept;
                lane_ctrl.rd   = take_block;
            end
            S_ACC: begin
                lane_addr     = r_bc;
                lane_ctrl.acc = 1'b1;
                lane_ctrl.go  = r_band_end;
            end
            S_DIV: begin
                load_out = lanes_idle && (!r_out_valid || i_m_axis_tready);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
        end
    end

    // what the accepted pixel needs once it reaches the column memory
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bc        <= pos_bc;
            r_band_end  <= pos_info.band_end;
            r_first_row <= pos_info.first_row;
            r_last      <= pos_info.last;
        end
    end

    assign o_s_axis_tready = s_ready;

    // ---- channel lanes ------------------------------------------------------
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_en[g] = (g == 0) ? 1'b1 : !r_mono_mode;

        bads_lane #(
            .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
            .SAMPLE_BITS   (SAMPLE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (lane_en[g]),
            .i_ctrl   (lane_ctrl),
            .i_addr   (lane_addr),
            .i_sample (i_s_axis_tdata[g*SAMPLE_W +: SAMPLE_BITS]),
            .i_area   (r_block_area),
            .o_avg    (lane_avg[g]),
            .o_busy   (lane_busy[g])
        );
    end

    // ---- merge into the output register -------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_avg  <= lane_avg;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_avg[2], r_out_avg[1], r_out_avg[0]};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lane_busy == '0) || (lane_busy == '1))
        else $error("channel dividers out of step");
    a_block_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_block |=> (r_state == S_ACC))
        else $error("block row end did not reach the column memory");
    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DIV))
        else $error("output beat raised outside the divide step");
`endif

endmodule

`default_nettype wire
